// File: rtl/ctpt_pkg.sv
// shared types, codes and constants of the cover position tracker
`default_nettype none

package ctpt_pkg;

    localparam int POS_FRAC_BITS = 24;
    localparam int POS_W         = POS_FRAC_BITS + 1;
    localparam int COUNT_BITS    = 8;
    localparam int REG_W         = 20;
    localparam int TIME_W        = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int DIV_CNT_W     = $clog2(POS_FRAC_BITS);

    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1) << POS_FRAC_BITS;
    localparam logic [POS_W-1:0] POS_HALF = POS_W'(1) << (POS_FRAC_BITS - 1);

    // item kinds
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_STOP = 2'd1;
    localparam logic [1:0] FUNC_MOVE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_INTV    = 2'd3;

    localparam logic [REG_W-1:0] OPEN_TIME_RST   = 20'd30000;
    localparam logic [REG_W-1:0] CLOSE_TIME_RST  = 20'd30000;
    localparam logic [REG_W-1:0] SENSOR_TOUT_RST = 20'd2000;
    localparam logic [REG_W-1:0] PUB_INTV_RST    = 20'd1000;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_MOVE  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_STOP = 2'd1,
        PEND_MOVE = 2'd2
    } pend_t;

    typedef enum logic [1:0] {
        DIR_IDLE  = 2'd0,
        DIR_OPEN  = 2'd1,
        DIR_CLOSE = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        PULSE_NONE  = 2'd0,
        PULSE_OPEN  = 2'd1,
        PULSE_CLOSE = 2'd2,
        PULSE_STOP  = 2'd3
    } pulse_t;

    typedef enum logic [2:0] {
        C_WAIT   = 3'd0,
        C_EXEC   = 3'd1,
        C_DIV    = 3'd2,
        C_FINISH = 3'd3,
        C_OUT    = 3'd4
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [TIME_W-1:0] now_ms;
        logic [7:0]       moving_count;
        logic [24:0]      goal_position;
    } ctpt_in_t;

    typedef struct packed {
        logic [1:0]  drive_pulse;
        logic        publish;
        logic [24:0] cover_position;
        logic [1:0]  direction;
        logic [1:0]  phase;
    } ctpt_out_t;

    typedef struct packed {
        logic load_in;
        logic exec_step;
        logic div_start;
        logic div_step;
        logic finish_step;
        logic load_out;
    } ctpt_cmd_t;

    typedef struct packed {
        logic move_tick;
        logic div_needed;
        logic div_last;
    } ctpt_stat_t;

endpackage

`default_nettype wire

// File: rtl/ctpt_div.sv
// restoring fractional divider, one quotient bit per cycle while step is high
`default_nettype none

module ctpt_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              step,
    input  wire logic [ctpt_pkg::REG_W-1:0]        dividend,
    input  wire logic [ctpt_pkg::REG_W-1:0]        divisor,
    output logic      [ctpt_pkg::POS_FRAC_BITS-1:0] quotient,
    output logic                                   last
);
    import ctpt_pkg::*;

    logic [REG_W-1:0]         rem_reg, rem_next;
    logic [REG_W-1:0]         div_reg, div_next;
    logic [POS_FRAC_BITS-1:0] quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [REG_W:0]           shifted;
    logic                     fits;

    // dividend is always below divisor, so remainder keeps REG_W bits
    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        rem_next = rem_reg;
        div_next = div_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = dividend;
            div_next = divisor;
            cnt_next = '0;
        end
        else if (step)
        begin
            rem_next = fits ? REG_W'(shifted - {1'b0, div_reg}) : shifted[REG_W-1:0];
            quo_next = {quo_reg[POS_FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign last     = cnt_reg == DIV_CNT_W'(POS_FRAC_BITS - 1);

endmodule

`default_nettype wire

// File: rtl/ctpt_dp.sv
// datapath: tracker state, config registers, travel arithmetic, result register
`default_nettype none

module ctpt_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ctpt_pkg::ctpt_cmd_t             cmd,
    output ctpt_pkg::ctpt_stat_t                 stat,
    input  wire ctpt_pkg::ctpt_in_t              in_data,
    output ctpt_pkg::ctpt_out_t                  out_data,
    input  wire logic                            cfg_we,
    input  wire logic [ctpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ctpt_pkg::REG_W-1:0]      cfg_data
);
    import ctpt_pkg::*;

    localparam int DIFF_W = POS_W + 5;

    // configuration
    logic [REG_W-1:0] open_time_reg, close_time_reg, sensor_tout_reg, pub_intv_reg;

    // tracker state
    phase_t            phase_reg, phase_next;
    pend_t             pending_reg, pending_next;
    dir_t              dir_reg, dir_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  target_reg, target_next;
    logic [COUNT_BITS-1:0] snap_reg, snap_next;
    logic [TIME_W-1:0] mst_reg, mst_next;
    logic [TIME_W-1:0] lut_reg, lut_next;
    logic [TIME_W-1:0] lpt_reg, lpt_next;

    // item and result staging
    ctpt_in_t          in_reg, in_next;
    ctpt_out_t         out_reg, out_next;
    pulse_t            pulse_reg, pulse_next;
    logic              pub_reg, pub_next;
    logic              sat_reg, sat_next;

    // travel setup
    logic [TIME_W-1:0] lut_eff, elapsed;
    logic [REG_W-1:0]  t_sel, t_eff;
    logic              sat_now;
    logic [POS_FRAC_BITS-1:0] quotient;

    logic [TIME_W-1:0]     now_v;
    logic [COUNT_BITS-1:0] cnt_v;

    assign now_v = in_reg.now_ms;
    assign cnt_v = in_reg.moving_count[COUNT_BITS-1:0];

    assign lut_eff = (mst_reg > lut_reg) ? mst_reg : lut_reg;
    assign elapsed = now_v - lut_eff;
    assign t_sel   = (dir_reg == DIR_OPEN) ? open_time_reg : close_time_reg;
    assign t_eff   = (t_sel == '0) ? REG_W'(1) : t_sel;
    // at or beyond full travel time the increment saturates at a full travel (POS_ONE)
    assign sat_now = elapsed >= TIME_W'(t_eff);

    ctpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (elapsed[REG_W-1:0]),
        .divisor  (t_eff),
        .quotient (quotient),
        .last     (stat.div_last)
    );

    assign stat.move_tick  = (in_reg.func == FUNC_TICK) && (phase_reg == PH_MOVE);
    assign stat.div_needed = !sat_now;

    always_comb
    begin
        in_next  = cmd.load_in ? in_data : in_reg;
        sat_next = cmd.div_start ? sat_now : sat_reg;
        out_next = out_reg;
        if (cmd.load_out)
        begin
            out_next.drive_pulse    = pulse_reg;
            out_next.publish        = pub_reg;
            out_next.cover_position = pos_reg;
            out_next.direction      = dir_reg;
            out_next.phase          = phase_reg;
        end
    end

    always_comb
    begin : step_logic
        logic [POS_W-1:0]  goal_sat;
        logic [POS_W-1:0]  inc;
        logic [POS_W:0]    sum;
        logic [POS_W-1:0]  ps;
        logic [POS_W-1:0]  diff;
        logic [DIFF_W-1:0] diff20;
        logic [TIME_W-1:0] dt_start;
        logic [TIME_W-1:0] dt_pub;
        phase_t            ph;
        dir_t              dr;
        logic [COUNT_BITS-1:0] sn;
        pulse_t            pl;
        logic              pb;

        phase_next   = phase_reg;
        pending_next = pending_reg;
        dir_next     = dir_reg;
        pos_next     = pos_reg;
        target_next  = target_reg;
        snap_next    = snap_reg;
        mst_next     = mst_reg;
        lut_next     = lut_reg;
        lpt_next     = lpt_reg;
        pulse_next   = pulse_reg;
        pub_next     = pub_reg;

        goal_sat = (in_reg.goal_position > POS_ONE) ? POS_ONE : in_reg.goal_position;
        dt_start = now_v - mst_reg;
        dt_pub   = now_v - lpt_reg;
        inc      = sat_reg ? POS_ONE : {1'b0, quotient};
        sum      = {1'b0, pos_reg} + {1'b0, inc};
        ps       = pos_reg;
        diff     = '0;
        diff20   = '0;
        ph       = phase_reg;
        dr       = dir_reg;
        sn       = snap_reg;
        pl       = PULSE_NONE;
        pb       = 1'b0;

        if (cmd.exec_step)
        begin
            pulse_next = PULSE_NONE;
            pub_next   = 1'b0;
            if (in_reg.func == FUNC_STOP)
            begin
                pending_next = PEND_STOP;
            end
            else if (in_reg.func == FUNC_MOVE)
            begin
                target_next  = goal_sat;
                pending_next = PEND_MOVE;
            end
            else if (in_reg.func == FUNC_TICK)
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (pending_reg == PEND_MOVE)
                        begin
                            // start: pick direction toward the target
                            if (target_reg == POS_ONE || target_reg > pos_reg)
                            begin
                                pulse_next = PULSE_OPEN;
                                dir_next   = DIR_OPEN;
                            end
                            else if (target_reg == '0 || target_reg < pos_reg)
                            begin
                                pulse_next = PULSE_CLOSE;
                                dir_next   = DIR_CLOSE;
                            end
                            mst_next   = now_v;
                            lut_next   = '0;
                            pub_next   = 1'b1;
                            lpt_next   = now_v;
                            phase_next = PH_START;
                            snap_next  = cnt_v;
                        end
                        else if (pending_reg == PEND_STOP)
                        begin
                            pulse_next = PULSE_STOP;
                            dir_next   = DIR_IDLE;
                            pub_next   = 1'b1;
                            lpt_next   = now_v;
                            phase_next = PH_IDLE;
                            snap_next  = cnt_v;
                        end
                        pending_next = PEND_NONE;
                    end
                    PH_START:
                    begin
                        if (cnt_v > snap_reg)
                        begin
                            mst_next   = now_v;
                            phase_next = PH_MOVE;
                            snap_next  = cnt_v;
                        end
                        else if (dt_start > TIME_W'(sensor_tout_reg))
                        begin
                            pulse_next = PULSE_STOP;
                            dir_next   = DIR_IDLE;
                            pub_next   = 1'b1;
                            lpt_next   = now_v;
                            phase_next = PH_IDLE;
                            snap_next  = cnt_v;
                        end
                    end
                    PH_STOP:
                    begin
                        if (cnt_v < snap_reg || dt_start > TIME_W'(sensor_tout_reg))
                        begin
                            pulse_next = PULSE_STOP;
                            dir_next   = DIR_IDLE;
                            pub_next   = 1'b1;
                            lpt_next   = now_v;
                            phase_next = PH_IDLE;
                            snap_next  = cnt_v;
                        end
                    end
                    PH_MOVE:
                    begin
                        // moving ticks go through the travel path
                    end
                endcase
            end
        end
        else if (cmd.finish_step)
        begin
            // integrate travel since the last update
            if (dir_reg == DIR_OPEN)
            begin
                ps = (sum > {1'b0, POS_ONE}) ? POS_ONE : sum[POS_W-1:0];
            end
            else if (dir_reg == DIR_CLOSE)
            begin
                ps = (inc >= pos_reg) ? '0 : pos_reg - inc;
            end
            lut_next = now_v;

            if (dt_pub > TIME_W'(pub_intv_reg))
            begin
                pb       = 1'b1;
                lpt_next = now_v;
            end

            if (pending_reg == PEND_STOP)
            begin
                pl           = PULSE_STOP;
                ph           = PH_STOP;
                sn           = cnt_v;
                pending_next = PEND_NONE;
            end
            else if (pending_reg == PEND_MOVE)
            begin
                // new target lies behind: stop first
                if ((dr == DIR_OPEN && target_reg < ps) ||
                    (dr == DIR_CLOSE && target_reg > ps))
                begin
                    pl = PULSE_STOP;
                    ph = PH_STOP;
                    sn = cnt_v;
                end
            end

            if (ph == PH_MOVE)
            begin
                if (sn > cnt_v)
                begin
                    sn = cnt_v;
                end
                else if (sn < cnt_v || cnt_v == '0)
                begin
                    sn     = cnt_v;
                    diff   = (target_reg > ps) ? target_reg - ps : ps - target_reg;
                    diff20 = (DIFF_W'(diff) << 4) + (DIFF_W'(diff) << 2);
                    // motor stopped by itself: snap to target when close or count empty
                    if (cnt_v == '0 || diff20 < DIFF_W'(POS_ONE))
                    begin
                        ps       = target_reg;
                        pl       = PULSE_STOP;
                        dr       = DIR_IDLE;
                        pb       = 1'b1;
                        lpt_next = now_v;
                        ph       = PH_IDLE;
                        sn       = cnt_v;
                    end
                end

                // intermediate target reached
                if (target_reg != POS_ONE && target_reg != '0 &&
                    ((dr == DIR_OPEN && ps >= target_reg) ||
                     (dr == DIR_CLOSE && ps <= target_reg)))
                begin
                    pl = PULSE_STOP;
                    ph = PH_STOP;
                    sn = cnt_v;
                end
            end

            pos_next   = ps;
            phase_next = ph;
            dir_next   = dr;
            snap_next  = sn;
            pulse_next = pl;
            pub_next   = pb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_time_reg   <= OPEN_TIME_RST;
            close_time_reg  <= CLOSE_TIME_RST;
            sensor_tout_reg <= SENSOR_TOUT_RST;
            pub_intv_reg    <= PUB_INTV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OPEN_TIME:   open_time_reg   <= cfg_data;
                CFG_CLOSE_TIME:  close_time_reg  <= cfg_data;
                CFG_SENSOR_TOUT: sensor_tout_reg <= cfg_data;
                CFG_PUB_INTV:    pub_intv_reg    <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pending_reg <= PEND_NONE;
            dir_reg     <= DIR_IDLE;
            pos_reg     <= POS_HALF;
            target_reg  <= '0;
            snap_reg    <= '0;
            mst_reg     <= '0;
            lut_reg     <= '0;
            lpt_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            dir_reg     <= dir_next;
            pos_reg     <= pos_next;
            target_reg  <= target_next;
            snap_reg    <= snap_next;
            mst_reg     <= mst_next;
            lut_reg     <= lut_next;
            lpt_reg     <= lpt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        out_reg   <= out_next;
        pulse_reg <= pulse_next;
        pub_reg   <= pub_next;
        sat_reg   <= sat_next;
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// File: rtl/ctpt_ctrl.sv
// controller: sequences one item through the datapath and owns the handshakes
`default_nettype none

module ctpt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire ctpt_pkg::ctpt_stat_t stat,
    output ctpt_pkg::ctpt_cmd_t       cmd
);
    import ctpt_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_WAIT:
            begin
                if (in_valid)
                begin
                    state_next = C_EXEC;
                end
            end
            C_EXEC:
            begin
                if (!stat.move_tick)
                begin
                    state_next = C_OUT;
                end
                else if (stat.div_needed)
                begin
                    state_next = C_DIV;
                end
                else
                begin
                    state_next = C_FINISH;
                end
            end
            C_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = C_FINISH;
                end
            end
            C_FINISH:
            begin
                state_next = C_OUT;
            end
            C_OUT:
            begin
                if (slot_free)
                begin
                    state_next = C_WAIT;
                end
            end
            default:
            begin
                state_next = C_WAIT;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            C_WAIT:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            C_EXEC:
            begin
                cmd.exec_step = !stat.move_tick;
                cmd.div_start = stat.move_tick;
            end
            C_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            C_FINISH:
            begin
                cmd.finish_step = 1'b1;
            end
            C_OUT:
            begin
                cmd.load_out = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/cover_position_tracker_fsm_unit.sv
// top level of the motorized cover position tracker
//
//  channel   dir  handshake             payload
//  in        in   in_valid / in_ready   in_data   (func, now_ms, moving_count, goal_position)
//  out       out  out_valid / out_ready out_data  (drive_pulse, publish, cover_position,
//                                                  direction, phase)
//  cfg       in   cfg_we                cfg_index, cfg_data (20 bit travel and timer values)
//
// one item at a time: a command, or a tick outside the moving phase, goes from the
// accept state through the evaluate state to the output state and into the result register
// a tick in the moving phase runs the restoring divider, one quotient bit per cycle,
// between the evaluate and finish states; when elapsed time reaches full travel time
// the increment saturates and the divider is skipped
// reset puts the tracker at half open, idle, with reset values in the registers
// a result waits in the output register while the next item is accepted; a second
// result holds in the datapath state until that register is taken
`default_nettype none

module cover_position_tracker_fsm_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire ctpt_pkg::ctpt_in_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output ctpt_pkg::ctpt_out_t                 out_data,
    input  wire logic                           cfg_we,
    input  wire logic [ctpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ctpt_pkg::REG_W-1:0]     cfg_data
);
    import ctpt_pkg::*;

    // command and status between sequencer and datapath
    ctpt_cmd_t  cmd;
    ctpt_stat_t stat;

    // sequencer: accept, evaluate, divide, finish, hand off result
    ctpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // tracker state, timers, position arithmetic and result register
    ctpt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
